FILE: rtl/wris_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wris_pkg
// Shared types and constants for the weighted region index select block.
// ----------------------------------------------------------------------------
package wris_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int REGION_W = 6;
    localparam int WEIGHT_W = 24;
    localparam int COUNT_W  = 16;
    localparam int SEED_W   = 32;
    localparam int RES_W    = 22;
    localparam int RC_W     = 7;
    localparam int TW_W     = 30;
    localparam int TE_W     = 22;
    localparam int ENTRY_W  = WEIGHT_W + COUNT_W;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd2;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_REGION_COUNT  = 2'd0;
    localparam logic [1:0] REG_TOTAL_WEIGHT  = 2'd1;
    localparam logic [1:0] REG_TOTAL_ENTRIES = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_P,
        ST_SCAN,
        ST_DIV_E,
        ST_OUT
    } seq_state_t;

    // Remainder unit request and response
    typedef struct packed {
        logic              start;
        logic [SEED_W-1:0] dividend;
        logic [TW_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [TW_W-1:0] rem;
    } div_rsp_t;

endpackage

FILE: rtl/weighted_region_index_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_region_index_select_top
// Region table with weighted pick and flat entry index queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel (valid/ready). Kind 0 writes the weight
//   and entry count of a region and gives no result. Kind 1
//   picks a region by inverse cumulative weight; kind 2 maps a region and a
//   seed to an index in the flat entry space. Both give one result on the
//   m_ channel. Kind 3 is dropped.
//   Configuration registers sit on the APB port: region_count at 0x0,
//   total_weight at 0x4, total_entries at 0x8. Write them only while idle.
//   Throughput: one request at a time. Query time comes from the remainder
//   unit plus the table scan through the single read port, one entry a cycle.
//   Reset clears the sequencer and the registers (region_count to 1); the
//   table is undefined until written. When the receiver stalls, the result
//   waits in the output register; the next request is still taken and its
//   result is held inside until the output register frees.
// ----------------------------------------------------------------------------
module weighted_region_index_select_top #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wris_pkg::KIND_W-1:0]   s_kind,
    input  logic [wris_pkg::REGION_W-1:0] s_region,
    input  logic [wris_pkg::WEIGHT_W-1:0] s_weight_value,
    input  logic [wris_pkg::COUNT_W-1:0]  s_count_value,
    input  logic signed [wris_pkg::SEED_W-1:0] s_seed_value,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wris_pkg::RES_W-1:0]    m_result_index,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wris_pkg::PADDR_W-1:0]  paddr,
    input  logic [wris_pkg::PDATA_W-1:0]  pwdata,
    output logic [wris_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import wris_pkg::*;

    localparam int RW   = $clog2(MAX_REGIONS);
    localparam int CW   = $clog2(MAX_REGIONS + 1);
    localparam int UW   = (CW > RC_W) ? CW : RC_W;
    localparam int AXW  = (RW > REGION_W) ? RW : REGION_W;
    localparam int CMPW = (AXW > UW) ? AXW : UW;
    localparam int RUNW = WEIGHT_W + RW;
    localparam int OW   = COUNT_W + RW;
    localparam int PW   = (RUNW > TW_W) ? RUNW : TW_W;
    localparam int EW   = (OW > TE_W) ? OW : TE_W;

    // Configuration registers
    logic [RC_W-1:0] region_count_reg;
    logic [TW_W-1:0] total_weight_reg;
    logic [TE_W-1:0] total_entries_reg;

    // Sequencer registers
    seq_state_t         state_reg, state_next;
    logic [RW-1:0]      addr_reg, addr_next;
    logic               issue_done_reg, issue_done_next;
    logic               rd_v_reg, rd_v_next;
    logic [RW-1:0]      rd_idx_reg, rd_idx_next;
    logic [RW-1:0]      scan_last_reg, scan_last_next;
    logic               pick_reg, pick_next;
    logic [TW_W-1:0]    target_reg, target_next;
    logic [RUNW-1:0]    run_reg, run_next;
    logic [OW-1:0]      offset_reg, offset_next;
    logic               neg_reg, neg_next;
    logic [SEED_W-1:0]  mag_reg, mag_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    logic [RES_W-1:0]   m_result_index_reg, m_result_index_next;

    // Table and remainder unit hookup
    logic               tbl_we;
    logic [RW-1:0]      tbl_waddr;
    logic [ENTRY_W-1:0] tbl_wdata;
    logic               tbl_re;
    logic [ENTRY_W-1:0] tbl_rdata;
    logic [WEIGHT_W-1:0] rd_weight;
    logic [COUNT_W-1:0]  rd_count;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Derived request values
    logic [UW-1:0]      used_wide;
    logic [RW-1:0]      used_last;
    logic [AXW-1:0]     region_wide;
    logic               region_in_table;
    logic               region_in_use;
    logic [SEED_W-1:0]  seed_mag;
    logic [RUNW-1:0]    run_sum;
    logic [OW-1:0]      offset_sum;
    logic               cfg_write;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_count_reg  <= RC_W'(1);
            total_weight_reg  <= '0;
            total_entries_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_REGION_COUNT:  region_count_reg  <= pwdata[RC_W-1:0];
                REG_TOTAL_WEIGHT:  total_weight_reg  <= pwdata[TW_W-1:0];
                REG_TOTAL_ENTRIES: total_entries_reg <= pwdata[TE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_REGION_COUNT:  prdata = PDATA_W'(region_count_reg);
            REG_TOTAL_WEIGHT:  prdata = PDATA_W'(total_weight_reg);
            REG_TOTAL_ENTRIES: prdata = PDATA_W'(total_entries_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    // Clamp the region count to 1..MAX_REGIONS
    assign used_wide = (region_count_reg == '0) ? UW'(1) :
                       ((UW'(region_count_reg) > UW'(MAX_REGIONS)) ? UW'(MAX_REGIONS) :
                        UW'(region_count_reg));
    assign used_last = RW'(used_wide - UW'(1));

    assign region_wide     = AXW'(s_region);
    assign region_in_table = CMPW'(region_wide) < CMPW'(MAX_REGIONS);
    assign region_in_use   = CMPW'(region_wide) < CMPW'(used_wide);
    assign seed_mag        = s_seed_value[SEED_W-1] ? (~s_seed_value + SEED_W'(1))
                                                    : s_seed_value;

    // Table write straight from an accepted write request
    assign s_ready   = (state_reg == ST_IDLE);
    assign tbl_we    = s_valid && s_ready && (s_kind == KIND_WRITE) && region_in_table;
    assign tbl_waddr = region_wide[RW-1:0];
    assign tbl_wdata = {s_weight_value, s_count_value};
    assign tbl_re    = (state_reg == ST_SCAN) && !issue_done_reg;

    assign rd_weight  = tbl_rdata[ENTRY_W-1:COUNT_W];
    assign rd_count   = tbl_rdata[COUNT_W-1:0];
    assign run_sum    = run_reg + RUNW'(rd_weight);
    assign offset_sum = offset_reg + OW'(rd_count);

    wris_table #(
        .DEPTH (MAX_REGIONS),
        .AW    (RW)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (addr_reg),
        .rdata (tbl_rdata)
    );

    wris_rem_div u_rem_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer state register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_done_reg <= 1'b0;
            rd_v_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            rd_v_reg       <= rd_v_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg           <= addr_next;
        rd_idx_reg         <= rd_idx_next;
        scan_last_reg      <= scan_last_next;
        pick_reg           <= pick_next;
        target_reg         <= target_next;
        run_reg            <= run_next;
        offset_reg         <= offset_next;
        neg_reg            <= neg_next;
        mag_reg            <= mag_next;
        res_reg            <= res_next;
        m_result_index_reg <= m_result_index_next;
    end

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        state_next          = state_reg;
        addr_next           = addr_reg;
        issue_done_next     = issue_done_reg;
        rd_v_next           = 1'b0;
        rd_idx_next         = addr_reg;
        scan_last_next      = scan_last_reg;
        pick_next           = pick_reg;
        target_next         = target_reg;
        run_next            = run_reg;
        offset_next         = offset_reg;
        neg_next            = neg_reg;
        mag_next            = mag_reg;
        res_next            = res_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_result_index_next = m_result_index_reg;
        div_req.start       = 1'b0;
        div_req.dividend    = seed_mag;
        div_req.divisor     = total_weight_reg;

        unique case (state_reg)
            ST_IDLE: begin
                addr_next       = '0;
                issue_done_next = 1'b0;
                run_next        = '0;
                offset_next     = '0;
                neg_next        = s_seed_value[SEED_W-1];
                mag_next        = seed_mag;
                if (s_valid) begin
                    case (s_kind)
                        KIND_PICK: begin
                            pick_next      = 1'b1;
                            scan_last_next = used_last;
                            if (total_weight_reg == '0) begin
                                res_next   = RES_W'(used_last);
                                state_next = ST_OUT;
                            end else begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV_P;
                            end
                        end
                        KIND_ENTRY: begin
                            pick_next      = 1'b0;
                            scan_last_next = region_in_use ? region_wide[RW-1:0] : '0;
                            state_next     = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end

            // Remainder of |n| by the total weight
            ST_DIV_P: begin
                if (div_rsp.done) begin
                    target_next = div_rsp.rem;
                    if (neg_reg && (div_rsp.rem != '0)) begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // Stream the table through the read port
            ST_SCAN: begin
                if (!issue_done_reg) begin
                    rd_v_next = 1'b1;
                    if (addr_reg == scan_last_reg) begin
                        issue_done_next = 1'b1;
                    end else begin
                        addr_next = addr_reg + RW'(1);
                    end
                end
                if (rd_v_reg) begin
                    if (pick_reg) begin
                        run_next = run_sum;
                        if ((PW'(target_reg) < PW'(run_sum)) ||
                            (rd_idx_reg == scan_last_reg)) begin
                            res_next   = RES_W'(rd_idx_reg);
                            state_next = ST_OUT;
                        end
                    end else if (rd_idx_reg == scan_last_reg) begin
                        if (rd_count == '0) begin
                            res_next   = (EW'(offset_reg) < EW'(total_entries_reg)) ?
                                         RES_W'(offset_reg) : '0;
                            state_next = ST_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = mag_reg;
                            div_req.divisor  = TW_W'(rd_count);
                            state_next       = ST_DIV_E;
                        end
                    end else begin
                        offset_next = offset_sum;
                    end
                end
            end

            // Remainder of |n| by the region's entry count, plus the offset
            ST_DIV_E: begin
                if (div_rsp.done) begin
                    res_next   = RES_W'(EW'(offset_reg) + EW'(div_rsp.rem[COUNT_W-1:0]));
                    state_next = ST_OUT;
                end
            end

            // Hand the result to the output register once it frees
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_result_index_next = res_reg;
                    state_next          = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_result_index_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (state_reg == ST_IDLE || state_reg == ST_SCAN))
        else $error("remainder unit started outside idle or scan");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_P || state_reg == ST_DIV_E))
        else $error("remainder result arrived with no divide pending");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_we |-> (state_reg == ST_IDLE))
        else $error("table written while a query is in flight");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && rd_v_reg) |-> (rd_idx_reg <= scan_last_reg))
        else $error("scan read past its last entry");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && state_next == ST_IDLE) |=> m_valid_reg)
        else $error("result dropped on leaving the output state");

endmodule

FILE: rtl/wris_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wris_table
// Region table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wris_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [wris_pkg::ENTRY_W-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [wris_pkg::ENTRY_W-1:0] rdata
);
    import wris_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/wris_rem_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wris_rem_div
// Restoring remainder unit: one quotient bit a cycle.
// ----------------------------------------------------------------------------
module wris_rem_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  wris_pkg::div_req_t req,
    output wris_pkg::div_rsp_t rsp
);
    import wris_pkg::*;

    localparam int CNT_W = $clog2(SEED_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SEED_W-1:0]  dvd_reg;
    logic [TW_W-1:0]    dvs_reg;
    logic [TW_W-1:0]    rem_reg;
    logic [TW_W:0]      trial;
    logic               fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, dvd_reg[SEED_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == CNT_W'(1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SEED_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[SEED_W-2:0], 1'b0};
            rem_reg <= fits ? TW_W'(trial - {1'b0, dvs_reg}) : trial[TW_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule
